// ===== hdl/tat_pkg.sv =====
// Shared types and constants of the threshold alarm table.
`default_nettype none

package tat_pkg;

  localparam int unsigned TAT_SLOTS = 5;

  localparam logic [3:0] TAT_NO_SENSOR = 4'd15;
  localparam logic [3:0] TAT_MAX_CODE  = 4'd9;
  localparam logic [7:0] TAT_COUNT_MAX = 8'hFF;
  localparam logic [7:0] TAT_PLIM_RST  = 8'd3;
  localparam logic [7:0] TAT_HOLD_RST  = 8'd10;

  typedef logic [3:0]        tat_code_t;
  typedef logic [7:0]        tat_count_t;
  typedef logic signed [23:0] tat_value_t;

  typedef enum logic [1:0] {
    ACT_SET    = 2'd0,
    ACT_CLEAR  = 2'd1,
    ACT_SAMPLE = 2'd2
  } tat_action_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NO_ROOM   = 2'd1,
    ST_NOT_FOUND = 2'd2
  } tat_status_e;

  typedef enum logic {
    REG_PLIM    = 1'b0,
    REG_HOLDOFF = 1'b1
  } tat_reg_e;

endpackage

`default_nettype wire

// ===== hdl/tat_if.sv =====
// Request and response channel interfaces of the threshold alarm table.
`default_nettype none

interface tat_req_if import tat_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] action;
  tat_code_t  variable;
  tat_value_t sample_value;
  tat_value_t upper_limit;
  tat_value_t lower_limit;

  modport source (output valid, action, variable, sample_value, upper_limit, lower_limit,
                  input ready);
  modport sink   (input valid, action, variable, sample_value, upper_limit, lower_limit,
                  output ready);
endinterface

interface tat_rsp_if import tat_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       alarm_fired;
  tat_code_t  alarm_variable;
  tat_value_t alarm_value;

  modport source (output valid, status, alarm_fired, alarm_variable, alarm_value,
                  input ready);
  modport sink   (input valid, status, alarm_fired, alarm_variable, alarm_value,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/threshold_alarm_table.sv =====
// Threshold alarm table: slot matching, persistence counting and holdoff.
//
// Each request on req_i sets an alarm for a sensor, clears it, or presents a
// sample for it; the fourth action code changes nothing. Every request yields
// exactly one response on rsp_o with a status and, for a sample that fires,
// the sensor code and the sample value. A request is first captured in an
// input register and the slot table is searched; once the response register
// can take a new response, the selected slot is updated and the response
// register is loaded. One request is taken every cycle while the receiver
// does not stall. When the receiver stalls, the response is held and the
// request waiting in the input register stays there; req_i.ready drops only
// while both registers are full, so at most two requests are in flight.
// Reset empties the table (no slot active, no sensor held, all counters zero)
// and loads the persistence limit with 3 and the holdoff with 10. Both are
// written over the APB port at addresses 0 and 4; the user must write them
// only while no request is pending, a rule the block itself leaves unchecked.
`default_nettype none

module threshold_alarm_table import tat_pkg::*; #(
  parameter int unsigned SLOTS = TAT_SLOTS
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  tat_req_if.sink          req_i,
  tat_rsp_if.source        rsp_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  tat_count_t plim_q;
  tat_count_t holdoff_q;

  logic       in_valid_q;
  logic [1:0] act_q;
  tat_code_t  code_q;
  tat_value_t value_q;
  tat_value_t upper_in_q;
  tat_value_t lower_in_q;

  logic       out_valid_q;
  logic [1:0] status_q, status_d;
  logic       fired_q, fired_d;
  tat_code_t  avar_q, avar_d;
  tat_value_t aval_q, aval_d;

  logic [SLOTS-1:0] active_q, active_d;
  tat_code_t        sensor_q [SLOTS];
  tat_code_t        sensor_d [SLOTS];
  tat_value_t       upper_q  [SLOTS];
  tat_value_t       upper_d  [SLOTS];
  tat_value_t       lower_q  [SLOTS];
  tat_value_t       lower_d  [SLOTS];
  tat_count_t       over_q   [SLOTS];
  tat_count_t       over_d   [SLOTS];
  tat_count_t       under_q  [SLOTS];
  tat_count_t       under_d  [SLOTS];
  tat_count_t       hold_q   [SLOTS];
  tat_count_t       hold_d   [SLOTS];

  logic [SLOTS-1:0] hit_any, hit_act, free;
  logic [SLOTS-1:0] first_any, first_act, first_free, set_sel;

  tat_value_t sel_upper, sel_lower;
  tat_count_t sel_over, sel_under, sel_hold;
  tat_count_t over_inc, under_inc, over_new, under_new;
  logic       above, below, fire, code_ok;
  logic       commit, accept, wr_en;

  // Handshakes.
  assign commit      = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || commit;
  assign accept      = req_i.valid && req_i.ready;

  // Configuration registers.
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plim_q    <= TAT_PLIM_RST;
      holdoff_q <= TAT_HOLD_RST;
    end else if (wr_en) begin
      case (tat_reg_e'(paddr[2]))
        REG_PLIM:    plim_q    <= pwdata[7:0];
        REG_HOLDOFF: holdoff_q <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (tat_reg_e'(paddr[2]))
      REG_PLIM:    prdata = {24'd0, plim_q};
      REG_HOLDOFF: prdata = {24'd0, holdoff_q};
      default:     prdata = '0;
    endcase
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (commit) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q      <= req_i.action;
      code_q     <= req_i.variable;
      value_q    <= req_i.sample_value;
      upper_in_q <= req_i.upper_limit;
      lower_in_q <= req_i.lower_limit;
    end
  end

  // Slot search: lowest matching slot wins.
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      hit_any[i] = (sensor_q[i] == code_q);
      free[i]    = !active_q[i];
    end
  end

  assign hit_act    = hit_any & active_q;
  assign first_any  = hit_any & (~hit_any + 1'b1);
  assign first_act  = hit_act & (~hit_act + 1'b1);
  assign first_free = free & (~free + 1'b1);
  assign set_sel    = (|hit_any) ? first_any : first_free;
  assign code_ok    = (code_q <= TAT_MAX_CODE);

  always_comb begin
    sel_upper = '0;
    sel_lower = '0;
    sel_over  = '0;
    sel_under = '0;
    sel_hold  = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (first_act[i]) begin
        sel_upper = sel_upper | upper_q[i];
        sel_lower = sel_lower | lower_q[i];
        sel_over  = sel_over  | over_q[i];
        sel_under = sel_under | under_q[i];
        sel_hold  = sel_hold  | hold_q[i];
      end
    end
  end

  // Persistence counting for the selected slot.
  assign above     = (value_q > sel_upper);
  assign below     = (value_q < sel_lower);
  assign over_inc  = (sel_over == TAT_COUNT_MAX) ? sel_over : sel_over + 8'd1;
  assign under_inc = (sel_under == TAT_COUNT_MAX) ? sel_under : sel_under + 8'd1;
  assign over_new  = above ? over_inc : '0;
  assign under_new = (!above && below) ? under_inc : '0;
  assign fire      = (above || below) && ((over_new >= plim_q) || (under_new >= plim_q));

  always_comb begin
    active_d = active_q;
    sensor_d = sensor_q;
    upper_d  = upper_q;
    lower_d  = lower_q;
    over_d   = over_q;
    under_d  = under_q;
    hold_d   = hold_q;
    status_d = ST_DONE;
    fired_d  = 1'b0;
    avar_d   = '0;
    aval_d   = '0;
    case (tat_action_e'(act_q))
      ACT_SET: begin
        if (!code_ok) begin
          status_d = ST_NOT_FOUND;
        end else if (!(|set_sel)) begin
          status_d = ST_NO_ROOM;
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (set_sel[i]) begin
              active_d[i] = 1'b1;
              sensor_d[i] = code_q;
              upper_d[i]  = upper_in_q;
              lower_d[i]  = lower_in_q;
              over_d[i]   = '0;
              under_d[i]  = '0;
              hold_d[i]   = '0;
            end
          end
        end
      end
      ACT_CLEAR: begin
        if (!code_ok || !(|hit_any)) begin
          status_d = ST_NOT_FOUND;
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (first_any[i]) begin
              active_d[i] = 1'b0;
              over_d[i]   = '0;
              under_d[i]  = '0;
              hold_d[i]   = '0;
            end
          end
        end
      end
      ACT_SAMPLE: begin
        if (!code_ok || !(|hit_act)) begin
          status_d = ST_NOT_FOUND;
        end else begin
          for (int i = 0; i < SLOTS; i++) begin
            if (first_act[i]) begin
              if (sel_hold != '0) begin
                hold_d[i] = sel_hold - 8'd1;
              end else if (fire) begin
                over_d[i]  = '0;
                under_d[i] = '0;
                hold_d[i]  = holdoff_q;
              end else begin
                over_d[i]  = over_new;
                under_d[i] = under_new;
              end
            end
          end
          if (sel_hold == '0 && fire) begin
            fired_d = 1'b1;
            avar_d  = code_q;
            aval_d  = value_q;
          end
        end
      end
      default: ;
    endcase
  end

  // Slot table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        sensor_q[i] <= TAT_NO_SENSOR;
        over_q[i]   <= '0;
        under_q[i]  <= '0;
        hold_q[i]   <= '0;
      end
    end else if (commit) begin
      active_q <= active_d;
      for (int i = 0; i < SLOTS; i++) begin
        sensor_q[i] <= sensor_d[i];
        over_q[i]   <= over_d[i];
        under_q[i]  <= under_d[i];
        hold_q[i]   <= hold_d[i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      for (int i = 0; i < SLOTS; i++) begin
        upper_q[i] <= upper_d[i];
        lower_q[i] <= lower_d[i];
      end
    end
  end

  // Response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      status_q <= status_d;
      fired_q  <= fired_d;
      avar_q   <= avar_d;
      aval_q   <= aval_d;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = status_q;
  assign rsp_o.alarm_fired    = fired_q;
  assign rsp_o.alarm_variable = avar_q;
  assign rsp_o.alarm_value    = aval_q;

endmodule

`default_nettype wire

// ===== hdl/tat_checker.sv =====
// Port-level assertions of the threshold alarm table and their binding.
`default_nettype none

module tat_checker import tat_pkg::*; (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       req_valid_i,
  input wire logic       req_ready_i,
  input wire logic       rsp_valid_i,
  input wire logic       rsp_ready_i,
  input wire logic [1:0] status_i,
  input wire logic       alarm_fired_i,
  input wire tat_code_t  alarm_variable_i,
  input wire tat_value_t alarm_value_i
);

  // A response rising on an idle output belongs to a request that passed both registers.
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_valid_i) |-> $past(req_valid_i && req_ready_i, 2))
    else $error("response appeared without a request two cycles earlier");

  a_fire_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && alarm_fired_i |-> status_i == ST_DONE && alarm_variable_i <= TAT_MAX_CODE)
    else $error("alarm fired with a failing status or an invalid sensor code");

  a_quiet_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !alarm_fired_i |-> alarm_variable_i == '0 && alarm_value_i == '0)
    else $error("alarm fields not cleared on a response without an alarm");

  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(status_i) &&
      $stable(alarm_fired_i) && $stable(alarm_variable_i) && $stable(alarm_value_i))
    else $error("stalled response changed");

endmodule

bind threshold_alarm_table tat_checker u_tat_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req_i.valid),
  .req_ready_i      (req_i.ready),
  .rsp_valid_i      (rsp_o.valid),
  .rsp_ready_i      (rsp_o.ready),
  .status_i         (rsp_o.status),
  .alarm_fired_i    (rsp_o.alarm_fired),
  .alarm_variable_i (rsp_o.alarm_variable),
  .alarm_value_i    (rsp_o.alarm_value)
);

`default_nettype wire

// ===== tb/sv/tat_tb_pkg.sv =====
// Request and response records and the response scoreboard for the alarm table bench.
`timescale 1ns / 100ps

package tat_tb_pkg;
  import tat_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int unsigned REPORT_LIMIT = 10;

  typedef struct {
    logic [1:0] action;
    tat_code_t  variable;
    tat_value_t sample_value;
    tat_value_t upper_limit;
    tat_value_t lower_limit;
  } alarm_request_t;

  typedef struct {
    logic [1:0] status;
    logic       fired;
    tat_code_t  sensor;
    tat_value_t value;
  } alarm_response_t;

  class alarm_table_scoreboard;
    tat_count_t persist_limit;
    tat_count_t holdoff_reload;
    logic       slot_live [TAT_SLOTS];
    tat_code_t  slot_code [TAT_SLOTS];
    tat_value_t slot_hi [TAT_SLOTS];
    tat_value_t slot_lo [TAT_SLOTS];
    tat_count_t over_run [TAT_SLOTS];
    tat_count_t under_run [TAT_SLOTS];
    tat_count_t holdoff_left [TAT_SLOTS];
    alarm_response_t expected_responses [$];
    int unsigned mismatches;

    function new();
      persist_limit  = TAT_PLIM_RST;
      holdoff_reload = TAT_HOLD_RST;
      mismatches     = 0;
      for (int i = 0; i < TAT_SLOTS; i++) begin
        slot_live[i] = 1'b0;
        slot_code[i] = TAT_NO_SENSOR;
        slot_hi[i]   = '0;
        slot_lo[i]   = '0;
        clear_runs(i);
      end
    endfunction

    function void clear_runs(int slot);
      over_run[slot]     = '0;
      under_run[slot]    = '0;
      holdoff_left[slot] = '0;
    endfunction

    function void write_register(tat_reg_e idx, tat_count_t value);
      if (idx == REG_PLIM) begin
        persist_limit = value;
      end else begin
        holdoff_reload = value;
      end
    endfunction

    function int find_slot(tat_code_t code, bit live_only);
      for (int i = 0; i < TAT_SLOTS; i++) begin
        if (slot_code[i] == code && (!live_only || slot_live[i])) begin
          return i;
        end
      end
      return -1;
    endfunction

    // Works out the response to an accepted request and updates the table.
    function void note_request(alarm_request_t req);
      alarm_response_t rsp;
      int slot;
      bit out_of_band;
      rsp.status = ST_DONE;
      rsp.fired  = 1'b0;
      rsp.sensor = '0;
      rsp.value  = '0;
      if (req.action != ACT_UNUSED && req.variable > TAT_MAX_CODE) begin
        rsp.status = ST_NOT_FOUND;
      end else if (req.action == ACT_SET) begin
        slot = find_slot(req.variable, 1'b0);
        if (slot < 0) begin
          for (int i = TAT_SLOTS - 1; i >= 0; i--) begin
            if (!slot_live[i]) begin
              slot = i;
            end
          end
        end
        if (slot < 0) begin
          rsp.status = ST_NO_ROOM;
        end else begin
          slot_live[slot] = 1'b1;
          slot_code[slot] = req.variable;
          slot_hi[slot]   = req.upper_limit;
          slot_lo[slot]   = req.lower_limit;
          clear_runs(slot);
        end
      end else if (req.action == ACT_CLEAR) begin
        slot = find_slot(req.variable, 1'b0);
        if (slot < 0) begin
          rsp.status = ST_NOT_FOUND;
        end else begin
          slot_live[slot] = 1'b0;
          clear_runs(slot);
        end
      end else if (req.action == ACT_SAMPLE) begin
        slot = find_slot(req.variable, 1'b1);
        if (slot < 0) begin
          rsp.status = ST_NOT_FOUND;
        end else if (holdoff_left[slot] != 0) begin
          holdoff_left[slot]--;
        end else begin
          out_of_band = 1'b1;
          if (req.sample_value > slot_hi[slot]) begin
            if (over_run[slot] != TAT_COUNT_MAX) over_run[slot]++;
            under_run[slot] = '0;
          end else if (req.sample_value < slot_lo[slot]) begin
            if (under_run[slot] != TAT_COUNT_MAX) under_run[slot]++;
            over_run[slot] = '0;
          end else begin
            over_run[slot]  = '0;
            under_run[slot] = '0;
            out_of_band     = 1'b0;
          end
          if (out_of_band && (over_run[slot] >= persist_limit ||
                              under_run[slot] >= persist_limit)) begin
            over_run[slot]     = '0;
            under_run[slot]    = '0;
            holdoff_left[slot] = holdoff_reload;
            rsp.fired  = 1'b1;
            rsp.sensor = req.variable;
            rsp.value  = req.sample_value;
          end
        end
      end
      expected_responses.push_back(rsp);
    endfunction

    function void check_response(alarm_response_t got);
      alarm_response_t want;
      if (expected_responses.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("response with no request outstanding: status %0d alarm %0b sensor %0d value %0d",
                   got.status, got.fired, got.sensor, got.value);
        end
        return;
      end
      want = expected_responses.pop_front();
      if (got.status !== want.status || got.fired !== want.fired ||
          got.sensor !== want.sensor || got.value !== want.value) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("response mismatch: expected status %0d alarm %0b sensor %0d value %0d",
                   want.status, want.fired, want.sensor, want.value);
          $display("                   got      status %0d alarm %0b sensor %0d value %0d",
                   got.status, got.fired, got.sensor, got.value);
        end
      end
    endfunction

    function void drain_leftovers();
      while (expected_responses.size() != 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("response never arrived: status %0d alarm %0b sensor %0d value %0d",
                   expected_responses[0].status, expected_responses[0].fired,
                   expected_responses[0].sensor, expected_responses[0].value);
        end
        void'(expected_responses.pop_front());
      end
    endfunction

    function int unsigned pending();
      return expected_responses.size();
    endfunction
  endclass

endpackage

// ===== tb/sv/tb_threshold_alarm_table.sv =====
// Top-level bench of the threshold alarm table: stimulus, register writes and response checks.
`timescale 1ns / 100ps

module tb_threshold_alarm_table;
  import tat_pkg::*;
  import tat_tb_pkg::*;

  localparam int unsigned PHASES      = 6;
  localparam int unsigned PHASE_ITEMS = 125;
  localparam int unsigned HOLD_CYCLES = 80;
  localparam int          VALUE_MAX   = 8388607;
  localparam int          VALUE_MIN   = -8388608;

  localparam tat_code_t SENSOR_T   = 4'd0;
  localparam tat_code_t SENSOR_H   = 4'd1;
  localparam tat_code_t SENSOR_V   = 4'd2;
  localparam tat_code_t SENSOR_D   = 4'd3;
  localparam tat_code_t SENSOR_S   = 4'd4;
  localparam tat_code_t SENSOR_L   = 4'd5;
  localparam tat_code_t SENSOR_BAD = 4'd10;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tat_req_if req_bus ();
  tat_rsp_if rsp_bus ();

  alarm_table_scoreboard alarm_book;

  int          band_hi [10];
  int          band_lo [10];
  bit          band_known [10];
  tat_count_t  phase_plim [PHASES];
  tat_count_t  phase_hold [PHASES];
  bit          quiet;
  bit          hold_request;
  int unsigned hold_left;
  int unsigned stall_left;

  always #10 clk_i = ~clk_i;

  threshold_alarm_table DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req_bus),
    .rsp_o   (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  function automatic int clamp_value(int v);
    if (v > VALUE_MAX) return VALUE_MAX;
    if (v < VALUE_MIN) return VALUE_MIN;
    return v;
  endfunction

  function automatic int random_value();
    return int'(tat_value_t'($urandom));
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  task automatic send_request(logic [1:0] action, tat_code_t code, int sample, int upper,
                              int lower);
    alarm_request_t req;
    int unsigned gap;
    req.action       = action;
    req.variable     = code;
    req.sample_value = tat_value_t'(sample);
    req.upper_limit  = tat_value_t'(upper);
    req.lower_limit  = tat_value_t'(lower);
    req_bus.valid        <= 1'b1;
    req_bus.action       <= req.action;
    req_bus.variable     <= req.variable;
    req_bus.sample_value <= req.sample_value;
    req_bus.upper_limit  <= req.upper_limit;
    req_bus.lower_limit  <= req.lower_limit;
    do @(posedge clk_i); while (req_bus.ready !== 1'b1);
    alarm_book.note_request(req);
    gap = pick_gap();
    if (gap != 0) begin
      req_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic apb_write(tat_reg_e idx, tat_count_t value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, value};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    alarm_book.write_register(idx, value);
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    while (alarm_book.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_band(tat_code_t code);
    int unsigned r;
    int centre;
    int span;
    r      = $urandom_range(0, 19);
    centre = int'($urandom_range(0, 4000)) - 2000;
    span   = int'($urandom_range(0, 300));
    if (r == 0) begin
      band_hi[code] = random_value();
      band_lo[code] = random_value();
    end else if (r == 1) begin
      band_hi[code] = VALUE_MAX;
      band_lo[code] = VALUE_MIN;
    end else if (r == 2) begin
      band_hi[code] = centre - span;
      band_lo[code] = centre + span;
    end else begin
      band_hi[code] = centre + span;
      band_lo[code] = centre - span;
    end
    band_known[code] = 1'b1;
    send_request(ACT_SET, code, random_value(), band_hi[code], band_lo[code]);
  endtask

  function automatic int pick_sample(tat_code_t code);
    int unsigned k;
    int hi;
    int lo;
    k  = $urandom_range(0, 9);
    hi = band_hi[code];
    lo = band_lo[code];
    if (k < 4) return clamp_value(hi + 1 + int'($urandom_range(0, 20)));
    if (k < 8) return clamp_value(lo - 1 - int'($urandom_range(0, 20)));
    if (k < 9) begin
      if (lo <= hi) return lo + int'($urandom_range(0, hi - lo));
      return (hi + lo) / 2;
    end
    return random_value();
  endfunction

  // Mostly samples against bands that were set, with some table churn and noise.
  task automatic run_phase(int unsigned items);
    int unsigned r;
    tat_code_t code;
    for (int unsigned n = 0; n < items; n++) begin
      r    = $urandom_range(0, 99);
      code = tat_code_t'($urandom_range(0, 9));
      if (r < 8) begin
        set_band(code);
      end else if (r < 12) begin
        send_request(ACT_CLEAR, code, random_value(), random_value(), random_value());
      end else if (r < 18) begin
        send_request(2'($urandom_range(0, 3)), tat_code_t'($urandom_range(0, 15)),
                     random_value(), random_value(), random_value());
      end else begin
        for (int t = 0; t < 3 && !band_known[code]; t++) begin
          code = tat_code_t'($urandom_range(0, 9));
        end
        send_request(ACT_SAMPLE, code, pick_sample(code), random_value(), random_value());
      end
    end
    req_bus.valid <= 1'b0;
  endtask

  initial begin
    psel                 <= 1'b0;
    penable              <= 1'b0;
    pwrite               <= 1'b0;
    paddr                <= '0;
    pwdata               <= '0;
    req_bus.valid        <= 1'b0;
    req_bus.action       <= '0;
    req_bus.variable     <= '0;
    req_bus.sample_value <= '0;
    req_bus.upper_limit  <= '0;
    req_bus.lower_limit  <= '0;
    rst_ni               <= 1'b0;
    quiet        = 1'b0;
    hold_request = 1'b0;
    phase_plim   = '{8'd1, 8'd0, 8'd255, 8'd2, 8'd3, 8'd3};
    phase_hold   = '{8'd0, 8'd2, 8'd255, 8'd1, 8'd10, 8'd10};
    phase_plim[PHASES-1] = tat_count_t'($urandom_range(1, 255));
    phase_hold[PHASES-1] = tat_count_t'($urandom_range(0, 255));
    alarm_book = new();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Requests against an empty table, bad sensor codes and the unused action.
    send_request(ACT_SAMPLE, SENSOR_T, 100, 0, 0);
    send_request(ACT_CLEAR, SENSOR_H, 0, 0, 0);
    send_request(ACT_SET, SENSOR_BAD, 0, 1000, -1000);
    send_request(ACT_CLEAR, TAT_NO_SENSOR, 0, 0, 0);
    send_request(ACT_SAMPLE, SENSOR_BAD, 0, 0, 0);
    send_request(ACT_UNUSED, TAT_NO_SENSOR, -1, -1, -1);
    // Widest band: the extreme samples are both in range.
    send_request(ACT_SET, SENSOR_T, 0, VALUE_MAX, VALUE_MIN);
    send_request(ACT_SAMPLE, SENSOR_T, VALUE_MAX, 0, 0);
    send_request(ACT_SAMPLE, SENSOR_T, VALUE_MIN, 0, 0);
    // The third over-limit sample fires, the fourth falls in the holdoff.
    send_request(ACT_SET, SENSOR_H, 0, 100, -100);
    repeat (4) send_request(ACT_SAMPLE, SENSOR_H, 101, 0, 0);
    // Re-setting the slot clears the holdoff; crossed limits test the upper side first.
    send_request(ACT_SET, SENSOR_H, 0, -50, 50);
    send_request(ACT_SAMPLE, SENSOR_H, 0, 0, 0);
    repeat (3) send_request(ACT_SAMPLE, SENSOR_H, -60, 0, 0);
    // Fill the table, overflow it, then free a slot and take it over.
    send_request(ACT_SET, SENSOR_V, 0, 10, -10);
    send_request(ACT_SET, SENSOR_D, 0, 10, -10);
    send_request(ACT_SET, SENSOR_S, 0, 10, -10);
    send_request(ACT_SET, SENSOR_L, 0, 10, -10);
    send_request(ACT_CLEAR, SENSOR_D, 0, 0, 0);
    send_request(ACT_CLEAR, SENSOR_D, 0, 0, 0);
    send_request(ACT_SET, SENSOR_L, 0, 10, -10);
    send_request(ACT_SAMPLE, SENSOR_D, 50, 0, 0);
    req_bus.valid <= 1'b0;

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      apb_write(REG_PLIM, phase_plim[p]);
      apb_write(REG_HOLDOFF, phase_hold[p]);
      quiet = (p == 3);
      if (p == 1) hold_request = 1'b1;
      run_phase(PHASE_ITEMS);
    end

    for (int c = 0; c < 2000 && alarm_book.pending() != 0; c++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    alarm_book.drain_leftovers();
    if (alarm_book.mismatches == 0) begin
      $display("threshold_alarm_table regression: pass");
    end else begin
      $display("threshold_alarm_table regression: fail");
    end
    $finish;
  end

  initial begin
    alarm_response_t got;
    int unsigned r;
    rsp_bus.ready <= 1'b0;
    hold_left  = 0;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
        got.status = rsp_bus.status;
        got.fired  = rsp_bus.alarm_fired;
        got.sensor = rsp_bus.alarm_variable;
        got.value  = rsp_bus.alarm_value;
        alarm_book.check_response(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        rsp_bus.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
        r = $urandom_range(0, 99);
        if (!quiet && r >= 95) begin
          stall_left = $urandom_range(8, 30);
        end else if (!quiet && r >= 75) begin
          stall_left = $urandom_range(1, 3);
        end
      end
    end
  end

  initial begin
    #10_000_000;
    $display("threshold_alarm_table regression: fail");
    $finish;
  end

endmodule
